### rtl/bfm_pkg.sv
// ============================================================================
// Bloom filter package
// Shared constants, codes and types of the Bloom filter with MurmurHash3.
// ============================================================================
package bfm_pkg;

    // Filter geometry.
    localparam int MAX_BITS   = 65536;
    localparam int MAX_HASHES = 6;
    localparam int ADDR_W     = $clog2(MAX_BITS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int HIDX_W     = $clog2(MAX_HASHES + 1);
    localparam int HCNT_W     = 3;

    // The bit store is kept as rows of ROW_W bits.
    localparam int ROW_W      = 32;
    localparam int SEL_W      = $clog2(ROW_W);
    localparam int ROW_ADDR_W = ADDR_W - SEL_W;
    localparam int ROWS       = MAX_BITS / ROW_W;

    // The remainder unit retires two dividend bits a cycle.
    localparam int HASH_W     = 32;
    localparam int MOD_STEPS  = HASH_W / 2;
    localparam int STEP_W     = $clog2(MOD_STEPS);

    // Probe queue between the hash front end and the memory back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration and data bus widths.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // MurmurHash3 x86_32 constants.
    localparam logic [HASH_W-1:0] MM_C1 = 32'hcc9e_2d51;
    localparam logic [HASH_W-1:0] MM_C2 = 32'h1b87_3593;
    localparam logic [HASH_W-1:0] MM_N  = 32'he654_6b64;
    localparam logic [HASH_W-1:0] MM_F1 = 32'h85eb_ca6b;
    localparam logic [HASH_W-1:0] MM_F2 = 32'hc2b2_ae35;
    localparam logic [HASH_W-1:0] MM_LEN = 32'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT_COUNT  = 4'd0,
        CFG_HASH_COUNT = 4'd1,
        CFG_SEED_0     = 4'd2,
        CFG_SEED_1     = 4'd3,
        CFG_SEED_2     = 4'd4,
        CFG_SEED_3     = 4'd5,
        CFG_SEED_4     = 4'd6,
        CFG_SEED_5     = 4'd7
    } cfg_idx_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_QUERY  = 1'b1
    } cmd_t;

    // Effective configuration as seen by the hash front end.
    typedef struct packed {
        logic [CNT_W-1:0]                    m;
        logic [HIDX_W-1:0]                   k;
        logic [MAX_HASHES-1:0][HASH_W-1:0]   seed;
    } cfg_t;

    // One bit access handed from the front end to the back end.
    typedef struct packed {
        logic              query;
        logic              last;
        logic [ADDR_W-1:0] addr;
    } probe_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MIX,
        F_H1,
        F_H2,
        F_H3,
        F_H4,
        F_MOD,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_CHECK
    } back_state_t;

endpackage

### rtl/bloom_filter_murmur3.sv
// ============================================================================
// Bloom filter with MurmurHash3 x86_32
// Membership store: inserts keys into and queries keys against a bit store.
// ============================================================================
// Usage:
// An item is a command (insert or query) and a 32-bit key. It is taken at a
// rising edge where start is high and busy is low. For each configured hash
// function the key is hashed with its seed, reduced modulo bit_count, and
// the addressed bit is set (insert) or tested (query).
// Each item gives one result beat: done is high for exactly one cycle and
// found carries the answer in that cycle (always 0 for an insert). The
// receiver cannot stall; busy stays high until that beat has been shown.
// Sequence: the front end mixes the key once, then for each of the k hash
// functions it hashes the mixed key with its seed, reduces the hash and
// pushes the bit address; the back end then tests or sets the addressed bit.
// The next item can be taken in the cycle after the result beat. The run
// time is set by the shared 32x32 multiplier of the hash front end and its
// remainder unit, which retires two hash bits a cycle.
// Configuration: registers are written through cfg_valid/cfg_index/
// cfg_data, by the user only while the block is idle (the block has no check
// for it); cfg_ready is always high and writes to unused indexes are dropped.
// Reset: registers take their defaults, then a clearing pass zeroes the
// 2048 rows of the bit store, one row a cycle, with busy held high.
// ============================================================================
module bloom_filter_murmur3 import bfm_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  cmd,
    input  logic [HASH_W-1:0]     key,
    output logic                  done,
    output logic                  found,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers.
    logic [CNT_W-1:0]                  bit_count_reg;
    logic [HCNT_W-1:0]                 hash_count_reg;
    logic [MAX_HASHES-1:0][HASH_W-1:0] seed_reg;

    // An item is in flight from its accept to its result beat.
    logic item_active_reg, item_active_next;

    logic   accept;
    logic   cfg_we;
    cfg_t   cfg;
    logic   q_push, q_pop, q_empty, q_full;
    probe_t q_din, q_dout;
    logic   clearing;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign busy      = clearing || item_active_reg;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg  <= CNT_W'(MAX_BITS);
            hash_count_reg <= HCNT_W'(3);
            for (int i = 0; i < MAX_HASHES; i++)
            begin
                seed_reg[i] <= HASH_W'(i);
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BIT_COUNT:  bit_count_reg  <= cfg_data[CNT_W-1:0];
                CFG_HASH_COUNT: hash_count_reg <= cfg_data[HCNT_W-1:0];
                CFG_SEED_0:     seed_reg[0]    <= cfg_data;
                CFG_SEED_1:     seed_reg[1]    <= cfg_data;
                CFG_SEED_2:     seed_reg[2]    <= cfg_data;
                CFG_SEED_3:     seed_reg[3]    <= cfg_data;
                CFG_SEED_4:     seed_reg[4]    <= cfg_data;
                CFG_SEED_5:     seed_reg[5]    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // A bit count of zero acts as one and a count above the store size is
    // held at the store size; the hash count is held between one and six.
    always_comb
    begin
        if (bit_count_reg == '0)
        begin
            cfg.m = CNT_W'(1);
        end
        else if (bit_count_reg > CNT_W'(MAX_BITS))
        begin
            cfg.m = CNT_W'(MAX_BITS);
        end
        else
        begin
            cfg.m = bit_count_reg;
        end
        if (hash_count_reg == '0)
        begin
            cfg.k = HIDX_W'(1);
        end
        else if (hash_count_reg > HCNT_W'(MAX_HASHES))
        begin
            cfg.k = HIDX_W'(MAX_HASHES);
        end
        else
        begin
            cfg.k = HIDX_W'(hash_count_reg);
        end
        cfg.seed = seed_reg;
    end

    // The item flag drops at the edge that ends the result beat.
    always_comb
    begin
        item_active_next = item_active_reg;
        if (accept)
        begin
            item_active_next = 1'b1;
        end
        else if (done)
        begin
            item_active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_active_reg <= 1'b0;
        end
        else
        begin
            item_active_reg <= item_active_next;
        end
    end

    bfm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (accept),
        .is_query (cmd == CMD_QUERY),
        .key      (key),
        .cfg      (cfg),
        .full     (q_full),
        .push     (q_push),
        .entry    (q_din)
    );

    bfm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty),
        .full  (q_full)
    );

    bfm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (q_empty),
        .head     (q_dout),
        .pop      (q_pop),
        .clearing (clearing),
        .done     (done),
        .found    (found)
    );

endmodule

### rtl/bfm_ram.sv
// ============================================================================
// Generic single-port RAM
// One address for read and write; read data is registered (read first).
// ============================================================================
module bfm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bfm_front.sv
// ============================================================================
// Bloom filter hash front end
// Hashes a key under each seed with one shared multiplier, reduces each hash
// modulo the bit count and pushes the bit addresses into the probe queue.
// ============================================================================
module bfm_front import bfm_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic              is_query,
    input  logic [HASH_W-1:0] key,
    input  cfg_t              cfg,
    input  logic              full,
    output logic              push,
    output probe_t            entry
);

    front_state_t      state_reg, state_next;
    logic              query_reg, query_next;
    logic [HIDX_W-1:0] idx_reg, idx_next;
    logic [HASH_W-1:0] k2_reg, k2_next;
    logic [HASH_W-1:0] prod_reg, prod_next;
    logic [HASH_W-1:0] dvd_reg, dvd_next;
    logic [ADDR_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic [HASH_W-1:0] mul_a, mul_b, mul_p;
    logic [HASH_W-1:0] mix_a, mix_r;
    logic [CNT_W-1:0]  part1, rem1, part2, rem2;
    logic              last;

    // The one multiplier of the front end; only the low word is kept.
    assign mul_p = mul_a * mul_b;

    // Two restoring remainder steps per cycle.
    always_comb
    begin
        part1 = {rem_reg, dvd_reg[HASH_W-1]};
        rem1  = (part1 >= cfg.m) ? part1 - cfg.m : part1;
        part2 = {rem1[ADDR_W-1:0], dvd_reg[HASH_W-2]};
        rem2  = (part2 >= cfg.m) ? part2 - cfg.m : part2;
    end

    assign last = (HIDX_W'(idx_reg + 1'b1) == cfg.k);

    assign entry.query = query_reg;
    assign entry.last  = last;
    assign entry.addr  = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            idx_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg <= query_next;
        k2_reg    <= k2_next;
        prod_reg  <= prod_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
    end

    always_comb
    begin
        state_next = state_reg;
        query_next = query_reg;
        idx_next   = idx_reg;
        k2_next    = k2_reg;
        prod_next  = prod_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        push       = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        mix_a      = '0;
        mix_r      = '0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (go)
                begin
                    query_next = is_query;
                    idx_next   = '0;
                    mul_a      = key;
                    mul_b      = MM_C1;
                    prod_next  = mul_p;
                    state_next = F_MIX;
                end
            end
            F_MIX:
            begin
                // The key block is the same for every seed, so it is mixed once.
                mul_a      = {prod_reg[16:0], prod_reg[31:17]};
                mul_b      = MM_C2;
                k2_next    = mul_p;
                state_next = F_H1;
            end
            F_H1:
            begin
                mix_a      = cfg.seed[idx_reg] ^ k2_reg;
                mix_r      = {mix_a[18:0], mix_a[31:19]};
                prod_next  = (mix_r << 2) + mix_r + MM_N;
                state_next = F_H2;
            end
            F_H2:
            begin
                mix_a      = prod_reg ^ MM_LEN;
                mix_r      = mix_a ^ (mix_a >> 16);
                mul_a      = mix_r;
                mul_b      = MM_F1;
                prod_next  = mul_p;
                state_next = F_H3;
            end
            F_H3:
            begin
                mix_a      = prod_reg ^ (prod_reg >> 13);
                mul_a      = mix_a;
                mul_b      = MM_F2;
                prod_next  = mul_p;
                state_next = F_H4;
            end
            F_H4:
            begin
                dvd_next   = prod_reg ^ (prod_reg >> 16);
                rem_next   = '0;
                step_next  = '0;
                state_next = F_MOD;
            end
            F_MOD:
            begin
                rem_next  = rem2[ADDR_W-1:0];
                dvd_next  = {dvd_reg[HASH_W-3:0], 2'b00};
                step_next = STEP_W'(step_reg + 1'b1);
                if (&step_reg)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    push = 1'b1;
                    if (last)
                    begin
                        state_next = F_IDLE;
                    end
                    else
                    begin
                        idx_next   = HIDX_W'(idx_reg + 1'b1);
                        state_next = F_H1;
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

### rtl/bfm_queue.sv
// ============================================================================
// Bloom filter probe queue
// Small first-in first-out buffer of bit accesses between front and back end.
// ============================================================================
module bfm_queue import bfm_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  probe_t din,
    input  logic   pop,
    output probe_t dout,
    output logic   empty,
    output logic   full
);

    probe_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? QPTR_W'(wr_reg + 1'b1) : wr_reg;
        rd_next  = do_pop ? QPTR_W'(rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = (QPTR_W + 1)'(cnt_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = (QPTR_W + 1)'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= din;
        end
    end

endmodule

### rtl/bfm_back.sv
// ============================================================================
// Bloom filter memory back end
// Clears the bit store after reset, then per probe reads a 32-bit row and
// sets (writes back) or tests one bit in it; reports one result per key.
// ============================================================================
module bfm_back import bfm_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   empty,
    input  probe_t head,
    output logic   pop,
    output logic   clearing,
    output logic   done,
    output logic   found
);

    back_state_t           state_reg, state_next;
    logic [ROW_ADDR_W-1:0] clr_reg, clr_next;
    probe_t                ent_reg, ent_next;
    logic                  all_reg, all_next;
    logic                  done_reg, done_next;
    logic                  found_reg, found_next;

    logic                  ram_we;
    logic [ROW_ADDR_W-1:0] ram_addr;
    logic [ROW_W-1:0]      ram_wdata, ram_rdata;
    logic                  bit_hit;

    bfm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign bit_hit  = ram_rdata[ent_reg.addr[SEL_W-1:0]];
    assign clearing = (state_reg == B_CLEAR);
    assign done     = done_reg;
    assign found    = found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            clr_reg   <= '0;
            all_reg   <= 1'b1;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            all_reg   <= all_next;
            done_reg  <= done_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        ent_next   = ent_reg;
        all_next   = all_reg;
        done_next  = 1'b0;
        found_next = 1'b0;
        pop        = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = head.addr[ADDR_W-1:SEL_W];
        ram_wdata  = '0;
        unique case (state_reg)
            B_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_reg;
                clr_next = ROW_ADDR_W'(clr_reg + 1'b1);
                if (&clr_reg)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                // The row read is issued here and its data is back next cycle.
                if (!empty)
                begin
                    pop        = 1'b1;
                    ent_next   = head;
                    state_next = B_CHECK;
                end
            end
            B_CHECK:
            begin
                ram_addr = ent_reg.addr[ADDR_W-1:SEL_W];
                if (!ent_reg.query)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata | (ROW_W'(1) << ent_reg.addr[SEL_W-1:0]);
                end
                all_next = all_reg & bit_hit;
                if (ent_reg.last)
                begin
                    done_next  = 1'b1;
                    found_next = ent_reg.query & all_reg & bit_hit;
                    all_next   = 1'b1;
                end
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

endmodule

### rtl/bfm_checker.sv
// ============================================================================
// Bloom filter port checker
// Watches the top level's ports for result beat and busy behavior.
// ============================================================================
module bfm_checker import bfm_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic found
);

    // A result beat lasts exactly one cycle.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // found is only raised together with a result beat.
    a_found_in_beat: assert property (@(posedge clk) disable iff (!rst_n)
        found |-> done)
        else $error("found raised outside a result beat");

    // An accepted item keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after an accept");

    // A result beat only comes while an item is in flight.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat while not busy");

endmodule

bind bloom_filter_murmur3 bfm_checker u_bfm_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .found (found)
);

### tb/tb_bloom_filter_murmur3.sv
// ============================================================================
// Bloom filter with MurmurHash3 testbench
// Drives insert and query commands into the filter under a series of
// filter settings and checks every result beat against a predictor that
// keeps its own copy of the settings and of the bit store.
// ============================================================================
module tb_bloom_filter_murmur3;
    import bfm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One command beat as it waits to be driven.
    typedef struct {
        cmd_t              op;
        logic [HASH_W-1:0] key;
    } member_req_t;

    // A write to any index past the last seed register must be dropped.
    localparam int FIRST_UNUSED_IDX = CFG_SEED_5 + 1;
    localparam int LAST_IDX         = (1 << CFG_IDX_W) - 1;

    // Cycles without any accepted beat before the run is declared hung.
    // The limit has to cover the clearing pass after reset and the run of one
    // key with six hash functions.
    localparam int HANG_LIMIT = 8000;

    // Cycles to keep watching after the last result, in case the block
    // shows a stray result beat late.
    localparam int DRAIN_CYCLES = 200;

    localparam int GAP_PCT = 36;
    localparam int RANDOM_ITEMS = 730;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  cmd = 1'b0;
    logic [HASH_W-1:0]     key = '0;
    logic                  done;
    logic                  found;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Commands waiting to be driven, and the found flags that the accepted
    // commands must produce, oldest first.
    member_req_t member_req_q[$];
    logic        expected_found_q[$];

    // Predictor state: the filter settings and the bit store.
    logic [CNT_W-1:0]  model_bit_count;
    logic [HCNT_W-1:0] model_hash_count;
    logic [HASH_W-1:0] model_seed[MAX_HASHES];
    bit                model_bits[MAX_BITS];

    // Seeds to be written by the next call of program_filter.
    logic [HASH_W-1:0] seed_plan[MAX_HASHES];

    int  mismatch_count = 0;
    int  stall_cycles = 0;
    bit  no_gaps = 1'b0;

    bloom_filter_murmur3 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .key       (key),
        .done      (done),
        .found     (found),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // MurmurHash3 x86_32 of a single 32-bit block (the key as four
    // little-endian bytes) under the given seed.
    function automatic logic [HASH_W-1:0] murmur_word(input logic [HASH_W-1:0] word,
                                                       input logic [HASH_W-1:0] seed);
        logic [HASH_W-1:0] blk;
        logic [HASH_W-1:0] h;
        blk = word * MM_C1;
        blk = {blk[16:0], blk[31:17]};
        blk = blk * MM_C2;
        h = seed ^ blk;
        h = {h[18:0], h[31:19]};
        h = h * 32'd5 + MM_N;
        h = h ^ MM_LEN;
        h = h ^ (h >> 16);
        h = h * MM_F1;
        h = h ^ (h >> 13);
        h = h * MM_F2;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic void clear_model();
        model_bit_count = CNT_W'(MAX_BITS);
        model_hash_count = HCNT_W'(3);
        for (int i = 0; i < MAX_HASHES; i++)
            model_seed[i] = HASH_W'(i);
        for (int a = 0; a < MAX_BITS; a++)
            model_bits[a] = 1'b0;
    endfunction

    function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        case (cfg_idx_t'(idx))
            CFG_BIT_COUNT:  model_bit_count = data[CNT_W-1:0];
            CFG_HASH_COUNT: model_hash_count = data[HCNT_W-1:0];
            CFG_SEED_0:     model_seed[0] = data;
            CFG_SEED_1:     model_seed[1] = data;
            CFG_SEED_2:     model_seed[2] = data;
            CFG_SEED_3:     model_seed[3] = data;
            CFG_SEED_4:     model_seed[4] = data;
            CFG_SEED_5:     model_seed[5] = data;
            default:        ;
        endcase
    endfunction

    // Applies one command to the model bit store and returns the found flag
    // that the block must report for it.
    function automatic logic probe_filter(input cmd_t op, input logic [HASH_W-1:0] word);
        int unsigned span;
        int unsigned hashes;
        int unsigned addr;
        logic        all_set;
        // A zero bit count or hash count means one; larger values saturate.
        span = (model_bit_count == 0) ? 1 : int'(model_bit_count);
        if (span > MAX_BITS)
            span = MAX_BITS;
        hashes = (model_hash_count == 0) ? 1 : int'(model_hash_count);
        if (hashes > MAX_HASHES)
            hashes = MAX_HASHES;
        all_set = 1'b1;
        for (int i = 0; i < hashes; i++)
        begin
            addr = murmur_word(word, model_seed[i]) % span;
            if (op == CMD_QUERY)
            begin
                if (!model_bits[addr])
                    all_set = 1'b0;
            end
            else
            begin
                model_bits[addr] = 1'b1;
            end
        end
        // An insert always reports not found.
        return (op == CMD_QUERY) && all_set;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t ns: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------------
    // Command driver: presents one command at a time and holds it until the
    // block takes it. Between commands it leaves start low at random, so that
    // gaps fall both while the block is still working and right after it
    // shows its result.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= CMD_INSERT;
            key <= '0;
        end
        else
        begin : drive_commands
            member_req_t next_req;
            logic        load;
            load = 1'b0;
            // The slot is free when nothing is shown or the shown beat is
            // taken at this edge.
            if (!start || !busy)
            begin
                if (member_req_q.size() != 0 &&
                    $urandom_range(99, 0) >= (no_gaps ? 0 : GAP_PCT))
                    load = 1'b1;
                if (load)
                begin
                    next_req = member_req_q.pop_front();
                    start <= 1'b1;
                    cmd <= next_req.op;
                    key <= next_req.key;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks result beats, follows register writes into the model,
    // predicts every accepted command, and watches for a hang. Doing all of
    // this in one block fixes the order of check and prediction at an edge
    // where a result and a new command meet.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin : watch_filter
            logic want;
            if (done)
            begin
                if (expected_found_q.size() == 0)
                begin
                    report_mismatch("result beat with no command outstanding");
                end
                else
                begin
                    want = expected_found_q.pop_front();
                    if (found !== want)
                        report_mismatch($sformatf("found is %b, expected %b", found, want));
                end
            end
            if (cfg_valid && cfg_ready)
                apply_setting(cfg_index, cfg_data);
            if (start && !busy)
                expected_found_q.insert(expected_found_q.size(),
                                        probe_filter(cmd_t'(cmd), key));

            if (done || (start && !busy) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= HANG_LIMIT)
            begin
                $display("TIMEOUT: no beat accepted for %0d cycles", HANG_LIMIT);
                $display("bloom_filter_murmur3 test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Returns at a rising edge once every queued command has been taken,
    // every result has come back and the block has dropped busy.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (member_req_q.size() != 0 || expected_found_q.size() != 0 || start || busy);
    endtask

    // One register write beat; called right after a rising edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Writes every register, seeds from seed_plan, then a write to an unused
    // index that the block must ignore.
    task automatic program_filter(input logic [CFG_DATA_W-1:0] count_word,
                                  input logic [CFG_DATA_W-1:0] hashes_word);
        write_reg(CFG_BIT_COUNT, count_word);
        write_reg(CFG_HASH_COUNT, hashes_word);
        for (int i = 0; i < MAX_HASHES; i++)
            write_reg(CFG_IDX_W'(CFG_SEED_0 + i), seed_plan[i]);
        write_reg(CFG_IDX_W'($urandom_range(LAST_IDX, FIRST_UNUSED_IDX)), $urandom());
        cfg_valid <= 1'b0;
        // Commands are queued away from the rising edge.
        @(negedge clk);
    endtask

    task automatic queue_cmd(input cmd_t op, input logic [HASH_W-1:0] word);
        member_req_t req;
        req.op = op;
        req.key = word;
        member_req_q.insert(member_req_q.size(), req);
    endtask

    function automatic logic [HASH_W-1:0] pick_key();
        case ($urandom_range(19, 0))
            0:       return '0;
            1:       return '1;
            2:       return {1'b1, {(HASH_W-1){1'b0}}};
            3:       return {1'b0, {(HASH_W-1){1'b1}}};
            default: return $urandom();
        endcase
    endfunction

    initial
    begin : stimulus
        logic [HASH_W-1:0]     key_pool[$];
        logic [HASH_W-1:0]     word;
        logic [CFG_DATA_W-1:0] count_word;
        int                    issued;
        int                    phase;
        int                    burst;
        int                    pick;

        clear_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // The block clears its bit store first and holds busy meanwhile.
        wait_idle();
        @(negedge clk);

        // Reset settings: a query of an empty filter, both key extremes,
        // and an insert followed by its query.
        queue_cmd(CMD_QUERY, '0);
        queue_cmd(CMD_INSERT, '0);
        queue_cmd(CMD_INSERT, '1);
        queue_cmd(CMD_QUERY, '0);
        queue_cmd(CMD_QUERY, '1);
        queue_cmd(CMD_QUERY, 32'h0000_0001);
        queue_cmd(CMD_INSERT, 32'ha5a5_5a5a);
        queue_cmd(CMD_QUERY, 32'ha5a5_5a5a);
        wait_idle();

        // Zero bit count and zero hash count: one hash, every key on bit 0.
        for (int i = 0; i < MAX_HASHES; i++)
            seed_plan[i] = $urandom();
        program_filter('0, '0);
        queue_cmd(CMD_QUERY, 32'h0000_1234);
        queue_cmd(CMD_INSERT, 32'hdead_beef);
        queue_cmd(CMD_QUERY, 32'h0000_1234);
        wait_idle();

        // Bit count and hash count above their maximums must saturate.
        program_filter(32'h0001_ffff, 32'h0000_0007);
        queue_cmd(CMD_INSERT, 32'h8000_0000);
        queue_cmd(CMD_QUERY, 32'h8000_0000);
        queue_cmd(CMD_QUERY, 32'h7fff_ffff);
        wait_idle();

        // Largest legal settings with extreme seeds.
        for (int i = 0; i < MAX_HASHES; i++)
            seed_plan[i] = (i % 2 == 0) ? '0 : '1;
        program_filter(CFG_DATA_W'(MAX_BITS), CFG_DATA_W'(MAX_HASHES));
        queue_cmd(CMD_INSERT, '1);
        queue_cmd(CMD_QUERY, '1);
        queue_cmd(CMD_QUERY, 32'h0000_ffff);
        wait_idle();

        // Two filter bits, one hash function.
        program_filter(32'd2, 32'd1);
        queue_cmd(CMD_INSERT, 32'h1357_9bdf);
        queue_cmd(CMD_QUERY, 32'h1357_9bdf);
        queue_cmd(CMD_QUERY, 32'hfdb9_7531);
        wait_idle();

        // Random phases. Each one picks new settings and then runs mostly
        // inserts and queries of keys already inserted, so that both answers
        // show up, plus queries of fresh keys. Keys inserted under earlier
        // settings stay in the pool and are queried under the new ones.
        issued = 0;
        phase = 0;
        while (issued < RANDOM_ITEMS)
        begin
            // Small bit counts fill the store quickly and give many hits;
            // the upper data bits are random and must be dropped.
            case ($urandom_range(9, 0))
                0, 1, 2: count_word = $urandom_range(64, 1);
                3, 4, 5: count_word = $urandom_range(4096, 65);
                6, 7:    count_word = $urandom_range(MAX_BITS, 4097);
                8:       count_word = ($urandom_range(1, 0) != 0) ? MAX_BITS : 0;
                default: count_word = $urandom();
            endcase
            count_word[CFG_DATA_W-1:CNT_W] = $urandom();
            for (int i = 0; i < MAX_HASHES; i++)
                seed_plan[i] = pick_key();
            program_filter(count_word, $urandom());

            // One long phase runs with no gaps between commands at all.
            no_gaps <= (phase == 3);
            burst = (phase == 3) ? 80 : $urandom_range(60, 15);
            for (int j = 0; j < burst; j++)
            begin
                pick = $urandom_range(99, 0);
                if (pick < 40 || key_pool.size() == 0)
                begin
                    word = pick_key();
                    key_pool.insert(key_pool.size(), word);
                    if (key_pool.size() > 64)
                        void'(key_pool.pop_front());
                    queue_cmd(CMD_INSERT, word);
                end
                else if (pick < 75)
                begin
                    queue_cmd(CMD_QUERY, key_pool[$urandom_range(key_pool.size() - 1, 0)]);
                end
                else if (pick < 90)
                begin
                    queue_cmd(CMD_QUERY, pick_key());
                end
                else
                begin
                    queue_cmd(CMD_INSERT, key_pool[$urandom_range(key_pool.size() - 1, 0)]);
                end
            end
            issued += burst;
            phase++;
            wait_idle();
        end

        // Keep watching for a stray late result beat.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("bloom_filter_murmur3 test passed");
        else
            $display("bloom_filter_murmur3 test failed");
        $finish;
    end

endmodule

### files.f
rtl/bfm_pkg.sv
rtl/bfm_ram.sv
rtl/bfm_front.sv
rtl/bfm_queue.sv
rtl/bfm_back.sv
rtl/bloom_filter_murmur3.sv
rtl/bfm_checker.sv
tb/tb_bloom_filter_murmur3.sv
